>>> design/fr_pkg.sv
// Shared types, codes and helpers for the frame reorder buffer.
package fr_pkg;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned SLOT_W    = 56;

  typedef enum logic [2:0] {
    CMD_ANNOUNCE,
    CMD_EMIT,
    CMD_BUFFER,
    CMD_OUTSIDE,
    CMD_STALE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_EMIT    = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_STALE   = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic [31:0]  number;
    logic [31:0]  handle;
    logic [23:0]  bytes;
  } fr_cmd_t;

  typedef struct packed {
    logic [31:0]  next_expected;
    logic         stream_done;
  } fr_view_t;

  typedef struct packed {
    logic         valid;
    logic [31:0]  number;
    logic [31:0]  handle;
    logic [23:0]  payload;
    status_t      status;
    logic         eos;
    logic         last;
  } fr_result_t;

  function automatic logic [23:0] payload_of(input logic [23:0] bytes);
    logic [23:0] hdr;
    hdr = 24'(HDR_BYTES);
    return (bytes >= hdr) ? (bytes - hdr) : 24'd0;
  endfunction

endpackage

>>> design/frame_reorder_buffer_core.sv
// Frame reorder buffer top level: classifier, command queue, executor and slot RAM.
//
// Usage: drive in_* and raise start; the word is taken on an edge where start
// is high and busy is low. in_req_type 0 delivers a frame, 1 announces the last
// frame number. Results come out on out_* with out_valid high for one cycle
// each; the receiver cannot stall, so every strobed word must be captured.
// A frame matching the expected number is emitted, followed by the run of
// buffered successors, one per cycle. Frames ahead within WINDOW are held in
// the slot RAM and give no result; repeats and others get a drop status.
// out_last_of_run marks the final result of one input word.
// busy stays high while a word is queued or a run of buffered successors
// drains via the single read port of the slot RAM, one read per cycle, so a
// new word is taken only once the previous one is done. After emitting the
// announced last frame, later words are accepted and discarded. Reset clears
// the expected number to 0, the last frame number to all ones and every slot
// valid bit; no clearing pass is run.
module frame_reorder_buffer_core #(
  parameter int unsigned WINDOW = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_frame_number,
  input  logic [31:0] in_frame_handle,
  input  logic [23:0] in_frame_bytes,
  output logic        out_valid,
  output logic [31:0] out_number,
  output logic [31:0] out_handle,
  output logic [23:0] out_payload_bytes,
  output logic [1:0]  out_status,
  output logic        out_end_of_stream,
  output logic        out_last_of_run
);

  import fr_pkg::*;

  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned QW = $bits(fr_cmd_t) + IW;

  fr_view_t         view;
  fr_cmd_t          f_cmd, b_cmd;
  logic [IW-1:0]    f_off, b_off;
  logic             push, pop, q_empty, back_active;
  logic [QW-1:0]    q_rdata;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;
  fr_result_t       res;

  assign busy = !q_empty || back_active;

  fr_front #(.WINDOW(WINDOW)) u_front (
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_frame_number (in_frame_number),
    .in_frame_handle (in_frame_handle),
    .in_frame_bytes  (in_frame_bytes),
    .view            (view),
    .push            (push),
    .cmd             (f_cmd),
    .offset          (f_off)
  );

  fr_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_cmd, f_off}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_cmd = fr_cmd_t'(q_rdata[QW-1:IW]);
  assign b_off = q_rdata[IW-1:0];

  fr_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (b_cmd),
    .offset    (b_off),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .view      (view),
    .active    (back_active),
    .res       (res)
  );

  fr_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = res.valid;
  assign out_number        = res.number;
  assign out_handle        = res.handle;
  assign out_payload_bytes = res.payload;
  assign out_status        = res.status;
  assign out_end_of_stream = res.eos;
  assign out_last_of_run   = res.last;

endmodule

>>> design/fr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/fr_fifo.sv
// Small register queue between the classifier and the executor.
module fr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (cnt_r != CW'(DEPTH));
  assign do_pop  = pop && (cnt_r != '0);
  assign empty   = (cnt_r == '0);
  assign rdata   = data_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

>>> design/fr_front.sv
// Front end: accepts a word and classifies it against the expected number.
module fr_front #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_req_type,
  input  logic [31:0]               in_frame_number,
  input  logic [31:0]               in_frame_handle,
  input  logic [23:0]               in_frame_bytes,
  input  fr_pkg::fr_view_t          view,
  output logic                      push,
  output fr_pkg::fr_cmd_t           cmd,
  output logic [$clog2(WINDOW)-1:0] offset
);

  import fr_pkg::*;

  localparam int unsigned IW = $clog2(WINDOW);

  logic [31:0] diff;

  assign diff   = in_frame_number - view.next_expected;
  assign offset = diff[IW-1:0];
  // words arriving after end of stream are dropped silently
  assign push   = start && !busy && !view.stream_done;

  always_comb begin
    cmd.number = in_frame_number;
    cmd.handle = in_frame_handle;
    cmd.bytes  = in_frame_bytes;
    if (in_req_type) begin
      cmd.kind = CMD_ANNOUNCE;
    end else if (diff == 32'd0) begin
      cmd.kind = CMD_EMIT;
    end else if (diff[31]) begin
      cmd.kind = CMD_STALE;
    end else if (diff >= 32'(WINDOW)) begin
      cmd.kind = CMD_OUTSIDE;
    end else begin
      cmd.kind = CMD_BUFFER;
    end
  end

endmodule

>>> design/fr_back.sv
// Back end: executes commands, owns the window and drains in-order runs.
module fr_back #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_empty,
  input  fr_pkg::fr_cmd_t           cmd,
  input  logic [$clog2(WINDOW)-1:0] offset,
  output logic                      pop,
  output logic                      ram_we,
  output logic [$clog2(WINDOW)-1:0] ram_waddr,
  output logic [fr_pkg::SLOT_W-1:0] ram_wdata,
  output logic [$clog2(WINDOW)-1:0] ram_raddr,
  input  logic [fr_pkg::SLOT_W-1:0] ram_rdata,
  output fr_pkg::fr_view_t          view,
  output logic                      active,
  output fr_pkg::fr_result_t        res
);

  import fr_pkg::*;

  localparam int unsigned IW = $clog2(WINDOW);

  back_state_t       state_r, state_nxt;
  logic [31:0]       next_exp_r, next_exp_nxt;
  logic [31:0]       final_r, final_nxt;
  logic              done_r, done_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  fr_result_t        res_r, res_nxt;

  logic [IW-1:0]     head_inc;
  logic [IW:0]       phys_sum;
  logic [IW-1:0]     phys;
  logic              emit_eos;
  logic              drain_eos;

  assign head_inc  = (head_r == IW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
  assign phys_sum  = {1'b0, head_r} + {1'b0, offset};
  assign phys      = (phys_sum >= (IW + 1)'(WINDOW)) ?
                     IW'(phys_sum - (IW + 1)'(WINDOW)) : phys_sum[IW-1:0];
  assign emit_eos  = (cmd.number == final_r);
  assign drain_eos = (next_exp_r == final_r);

  assign ram_raddr = head_inc;
  assign ram_waddr = phys;
  assign ram_wdata = {cmd.handle, cmd.bytes};

  assign view.next_expected = next_exp_r;
  assign view.stream_done   = done_r;
  assign active             = (state_r != BK_IDLE);
  assign res                = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_EMIT && !emit_eos && valid_r[head_inc]) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (drain_eos || !valid_r[head_inc]) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    ram_we       = 1'b0;
    next_exp_nxt = next_exp_r;
    final_nxt    = final_r;
    done_nxt     = done_r;
    head_nxt     = head_r;
    valid_nxt    = valid_r;
    res_nxt.valid   = 1'b0;
    res_nxt.number  = cmd.number;
    res_nxt.handle  = cmd.handle;
    res_nxt.payload = payload_of(cmd.bytes);
    res_nxt.status  = ST_STALE;
    res_nxt.eos     = 1'b0;
    res_nxt.last    = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          pop = 1'b1;
          case (cmd.kind)
            CMD_ANNOUNCE: begin
              final_nxt = cmd.number;
            end
            CMD_EMIT: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = ST_EMIT;
              res_nxt.eos    = emit_eos;
              res_nxt.last   = emit_eos || !valid_r[head_inc];
              next_exp_nxt   = cmd.number + 32'd1;
              head_nxt       = head_inc;
              done_nxt       = emit_eos;
            end
            CMD_BUFFER: begin
              if (valid_r[phys]) begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = ST_STALE;
              end else begin
                ram_we           = 1'b1;
                valid_nxt[phys]  = 1'b1;
              end
            end
            CMD_OUTSIDE: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = ST_OUTSIDE;
            end
            CMD_STALE: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = ST_STALE;
            end
            default: begin
              res_nxt.valid = 1'b0;
            end
          endcase
        end
      end
      BK_DRAIN: begin
        res_nxt.valid     = 1'b1;
        res_nxt.number    = next_exp_r;
        res_nxt.handle    = ram_rdata[SLOT_W-1:24];
        res_nxt.payload   = payload_of(ram_rdata[23:0]);
        res_nxt.status    = ST_EMIT;
        res_nxt.eos       = drain_eos;
        res_nxt.last      = drain_eos || !valid_r[head_inc];
        valid_nxt[head_r] = 1'b0;
        next_exp_nxt      = next_exp_r + 32'd1;
        head_nxt          = head_inc;
        done_nxt          = drain_eos;
      end
      default: begin
        res_nxt.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      next_exp_r <= '0;
      final_r    <= '1;
      done_r     <= 1'b0;
      head_r     <= '0;
      valid_r    <= '0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      next_exp_r <= next_exp_nxt;
      final_r    <= final_nxt;
      done_r     <= done_nxt;
      head_r     <= head_nxt;
      valid_r    <= valid_nxt;
      res_r      <= res_nxt;
    end
  end

endmodule

>>> verif/tb.sv
// Self-checking testbench for frame_reorder_buffer_core: in-order release, window and drops.

typedef struct {
  logic [31:0]     number;
  logic [31:0]     handle;
  logic [23:0]     payload;
  fr_pkg::status_t status;
  logic            eos;
  logic            last;
} frame_res_t;

class frame_sequencer;
  localparam int unsigned SLOTS = 32;

  logic [31:0] next_num;
  logic [31:0] final_num;
  bit          done;
  bit          slot_valid [SLOTS];
  logic [31:0] slot_handle [SLOTS];
  logic [23:0] slot_bytes [SLOTS];
  frame_res_t  pending[$];
  int          errors;

  function new();
    next_num  = '0;
    final_num = '1;
    done      = 1'b0;
    errors    = 0;
    foreach (slot_valid[k]) slot_valid[k] = 1'b0;
  endfunction

  function void push(logic [31:0] num, logic [31:0] handle, logic [23:0] bytes,
                     fr_pkg::status_t status, logic eos);
    frame_res_t r;
    r.number  = num;
    r.handle  = handle;
    r.payload = (bytes >= 24'(fr_pkg::HDR_BYTES)) ? bytes - 24'(fr_pkg::HDR_BYTES) : 24'd0;
    r.status  = status;
    r.eos     = eos;
    r.last    = 1'b0;
    pending.push_back(r);
  endfunction

  // Called for every accepted word.
  function void accept_word(logic req, logic [31:0] num, logic [31:0] handle,
                            logic [23:0] bytes);
    logic [31:0] offs;
    int n;
    if (done) return;
    if (req) begin
      final_num = num;
      return;
    end
    offs = num - next_num;
    if (offs != 0) begin
      if (offs[31]) begin
        push(num, handle, bytes, fr_pkg::ST_STALE, 1'b0);
      end else if (offs >= SLOTS) begin
        push(num, handle, bytes, fr_pkg::ST_OUTSIDE, 1'b0);
      end else if (slot_valid[offs]) begin
        push(num, handle, bytes, fr_pkg::ST_STALE, 1'b0);
      end else begin
        slot_valid[offs]  = 1'b1;
        slot_handle[offs] = handle;
        slot_bytes[offs]  = bytes;
        return;
      end
      pending[pending.size()-1].last = 1'b1;
      return;
    end
    n = 0;
    forever begin
      push(num, handle, bytes, fr_pkg::ST_EMIT, num == final_num);
      n++;
      next_num = num + 1;
      for (int k = 0; k + 1 < SLOTS; k++) begin
        slot_valid[k]  = slot_valid[k+1];
        slot_handle[k] = slot_handle[k+1];
        slot_bytes[k]  = slot_bytes[k+1];
      end
      slot_valid[SLOTS-1] = 1'b0;
      if (num == final_num) begin
        done = 1'b1;
        break;
      end
      if (!slot_valid[0] || n >= SLOTS) break;
      num           = next_num;
      handle        = slot_handle[0];
      bytes         = slot_bytes[0];
      slot_valid[0] = 1'b0;
    end
    pending[pending.size()-1].last = 1'b1;
  endfunction

  function void check_frame(logic [31:0] num, logic [31:0] handle, logic [23:0] pay,
                            logic [1:0] status, logic eos, logic last);
    frame_res_t e;
    if (pending.size() == 0) begin
      $error("unexpected result word: out_number %h", num);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (num !== e.number) begin
      $error("out_number: expected %h, actual %h", e.number, num);
      errors++;
    end
    if (handle !== e.handle) begin
      $error("out_handle: expected %h, actual %h", e.handle, handle);
      errors++;
    end
    if (pay !== e.payload) begin
      $error("out_payload_bytes: expected %0d, actual %0d", e.payload, pay);
      errors++;
    end
    if (status !== e.status) begin
      $error("out_status: expected %0d, actual %0d", e.status, status);
      errors++;
    end
    if (eos !== e.eos) begin
      $error("out_end_of_stream: expected %b, actual %b", e.eos, eos);
      errors++;
    end
    if (last !== e.last) begin
      $error("out_last_of_run: expected %b, actual %b", e.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fr_pkg::*;

  localparam int unsigned WIN         = 32;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_WAIT  = 2 * WIN + 8;
  localparam int unsigned RAND_ITEMS  = 175;

  localparam logic REQ_FRAME    = 1'b0;
  localparam logic REQ_ANNOUNCE = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [31:0] in_frame_number;
  logic [31:0] in_frame_handle;
  logic [23:0] in_frame_bytes;
  logic        out_valid;
  logic [31:0] out_number;
  logic [31:0] out_handle;
  logic [23:0] out_payload_bytes;
  logic [1:0]  out_status;
  logic        out_end_of_stream;
  logic        out_last_of_run;

  frame_sequencer sb = new();
  int             words_sent;
  int unsigned    stall_cnt;

  frame_reorder_buffer_core #(.WINDOW(WIN)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_frame_number   (in_frame_number),
    .in_frame_handle   (in_frame_handle),
    .in_frame_bytes    (in_frame_bytes),
    .out_valid         (out_valid),
    .out_number        (out_number),
    .out_handle        (out_handle),
    .out_payload_bytes (out_payload_bytes),
    .out_status        (out_status),
    .out_end_of_stream (out_end_of_stream),
    .out_last_of_run   (out_last_of_run)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        sb.check_frame(out_number, out_handle, out_payload_bytes, out_status,
                       out_end_of_stream, out_last_of_run);
      end
      if (start && busy === 1'b0) begin
        sb.accept_word(in_req_type, in_frame_number, in_frame_handle, in_frame_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt + 1 >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Entered and left right after a falling edge.
  task automatic send_word(logic req, logic [31:0] num, logic [31:0] handle,
                           logic [23:0] bytes);
    bit taken;
    start           <= 1'b1;
    in_req_type     <= req;
    in_frame_number <= num;
    in_frame_handle <= handle;
    in_frame_bytes  <= bytes;
    do begin
      @(posedge clk);
      taken = (busy === 1'b0);
      @(negedge clk);
    end while (!taken);
    words_sent++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_bytes();
    case ($urandom_range(0, 9))
      0:       return 24'($urandom_range(0, 3));
      1:       return 24'hFF_FFFF;
      2:       return 24'd4;
      default: return 24'($urandom);
    endcase
  endfunction

  // Last-frame number far from anything that will be emitted.
  function automatic logic [31:0] harmless_final();
    logic [31:0] v;
    v = $urandom;
    if (v - sb.next_num < 32'h0001_0000) v = v ^ 32'h8000_0000;
    return v;
  endfunction

  task automatic send_noise(logic [31:0] base);
    case ($urandom_range(0, 2))
      0:       send_word(REQ_FRAME, $urandom, $urandom, pick_bytes());
      1:       send_word(REQ_FRAME, base + $urandom_range(0, WIN + 3), $urandom, pick_bytes());
      default: send_word(REQ_ANNOUNCE, harmless_final(), $urandom, pick_bytes());
    endcase
  endtask

  // A shuffled run of consecutive frames starting at the expected number.
  task automatic run_batch(bit gaps);
    logic [31:0] base;
    int          ord[$];
    int          cnt;
    int          j;
    int          tmp;
    base = sb.next_num;
    cnt  = ($urandom_range(0, 7) == 0) ? WIN : $urandom_range(1, 12);
    for (int i = 0; i < cnt; i++) ord.push_back(i);
    for (int i = cnt - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      tmp    = ord[i];
      ord[i] = ord[j];
      ord[j] = tmp;
    end
    foreach (ord[i]) begin
      if ($urandom_range(0, 5) == 0) send_noise(base);
      send_word(REQ_FRAME, base + ord[i], $urandom, pick_bytes());
      if (gaps && $urandom_range(0, 2) == 0) pause($urandom_range(1, 3));
    end
  endtask

  initial begin
    logic [31:0] base;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_req_type     <= REQ_FRAME;
    in_frame_number <= '0;
    in_frame_handle <= '0;
    in_frame_bytes  <= '0;
    words_sent      = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(REQ_FRAME, 32'd0, 32'h0000_0000, 24'd4);
    send_word(REQ_FRAME, 32'd1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_word(REQ_FRAME, 32'd2, 32'h1234_5678, 24'd0);
    pause(2);
    send_word(REQ_FRAME, 32'd3, 32'hA5A5_5A5A, 24'd3);
    // announcing an already emitted frame must never end the stream
    send_word(REQ_ANNOUNCE, 32'd0, 32'h0, 24'd0);
    send_word(REQ_FRAME, 32'd6, 32'h0000_0006, 24'd5);
    send_word(REQ_FRAME, 32'd5, 32'h0000_0005, 24'd2);
    send_word(REQ_FRAME, 32'd6, 32'hDEAD_BEEF, 24'd100);
    send_word(REQ_FRAME, 32'd4 + WIN - 1, 32'h5555_5555, 24'd77);
    send_word(REQ_FRAME, 32'd4 + WIN, 32'hAAAA_AAAA, 24'd78);
    send_word(REQ_FRAME, 32'h8000_0003, 32'h0F0F_0F0F, 24'd9);
    send_word(REQ_FRAME, 32'h8000_0004, 32'hF0F0_F0F0, 24'd10);
    send_word(REQ_FRAME, 32'd3, 32'h3333_3333, 24'd11);
    pause(1);
    send_word(REQ_FRAME, 32'd4, 32'h4444_4444, 24'hFF_FFFF);

    while (words_sent < RAND_ITEMS) run_batch(1'b1);
    repeat (3) run_batch(1'b0);

    // end of stream, then words that must be ignored
    base = sb.next_num;
    send_word(REQ_ANNOUNCE, base + 3, $urandom, pick_bytes());
    send_word(REQ_FRAME, base + 5, $urandom, pick_bytes());
    send_word(REQ_FRAME, base + 2, $urandom, pick_bytes());
    send_word(REQ_FRAME, base + 1, $urandom, pick_bytes());
    send_word(REQ_FRAME, base + 3, $urandom, pick_bytes());
    send_word(REQ_FRAME, base, $urandom, pick_bytes());
    send_word(REQ_FRAME, base + 4, $urandom, pick_bytes());
    send_word(REQ_FRAME, $urandom, $urandom, pick_bytes());
    send_word(REQ_ANNOUNCE, $urandom, $urandom, pick_bytes());
    start <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected result words never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
design/fr_pkg.sv
design/fr_ram.sv
design/fr_fifo.sv
design/fr_front.sv
design/fr_back.sv
design/frame_reorder_buffer_core.sv
verif/tb.sv
